/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/core/tun_pkg.sv */
// Shared constants and types of the triangle unit normal core.
package tun_pkg;

    localparam int MINLEN_WIDTH = 36;
    localparam logic [MINLEN_WIDTH-1:0] MINLEN_RESET = 36'd6554;
    localparam int OUT_WIDTH = 16;

    // Flags that ride along with one normal component into the divider.
    typedef struct packed {
        logic neg;
        logic zero;
    } tun_flags_t;

endpackage

/* rtl/core/tun_cross_lane.sv */
// One lane: a cross product component, its magnitude, sign and square.
module tun_cross_lane
#(
    parameter int EW = 17,
    parameter int MW = 33
)
(
    input  logic                 clk,
    input  logic signed [EW-1:0] e_a,
    input  logic signed [EW-1:0] f_b,
    input  logic signed [EW-1:0] e_b,
    input  logic signed [EW-1:0] f_a,
    output logic [MW-1:0]        mag,
    output logic                 neg,
    output logic [2*MW-1:0]      sq
);

    logic signed [2*EW-1:0] p_reg, q_reg, p_next, q_next;
    logic signed [2*EW:0]   diff;
    logic [2*EW:0]          diff_abs;
    logic [MW-1:0]          mag_reg, mag_next, mag_d_reg;
    logic                   neg_reg, neg_next, neg_d_reg;
    logic [2*MW-1:0]        sq_reg, sq_next;

    // Two products of the component.
    assign p_next = e_a * f_b;
    assign q_next = e_b * f_a;

    // Difference split into sign and magnitude.
    assign diff     = (2*EW+1)'(p_reg) - (2*EW+1)'(q_reg);
    assign diff_abs = diff[2*EW] ? (2*EW+1)'(-diff) : (2*EW+1)'(diff);
    assign mag_next = diff_abs[MW-1:0];
    assign neg_next = diff[2*EW];

    // Square of the magnitude.
    assign sq_next = (2*MW)'(mag_reg) * (2*MW)'(mag_reg);

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        q_reg     <= q_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        mag_d_reg <= mag_reg;
        neg_d_reg <= neg_reg;
        sq_reg    <= sq_next;
    end

    assign mag = mag_d_reg;
    assign neg = neg_d_reg;
    assign sq  = sq_reg;

endmodule

/* rtl/core/tun_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with a side payload.
module tun_isqrt
#(
    parameter int RW = 34,
    parameter int PW = 102
)
(
    input  logic              clk,
    input  logic [2*RW-1:0]   rad,
    input  logic [PW-1:0]     side_in,
    output logic [RW-1:0]     root,
    output logic [PW-1:0]     side_out
);

    localparam int SW = 2 * RW;

    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [PW-1:0] side_reg [RW];

    genvar k;
    for (k = 0; k < RW; k++)
    begin : g_stage
        localparam int I = RW - 1 - k;
        logic [SW-1:0] rem_in, trial, rem_next;
        logic [RW-1:0] root_in, root_next;
        logic [PW-1:0] side_s;

        if (k == 0)
        begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_s  = side_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_s  = side_reg[k-1];
        end

        // Try setting this bit: (r + 2^I)^2 - r^2 = (2r + 2^I) * 2^I.
        assign trial = (SW'(root_in) << (I + 1)) | (SW'(1) << (2 * I));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << I);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_s;
        end
    end

    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

/* rtl/core/tun_div_lane.sv */
// One lane: rounded magnitude times 2^F over the length, pipelined one bit a stage.
module tun_div_lane
    import tun_pkg::*;
#(
    parameter int RW = 34,
    parameter int MW = 33,
    parameter int F  = 14
)
(
    input  logic                        clk,
    input  logic [MW-1:0]               mag,
    input  logic [RW-1:0]               len,
    input  tun_flags_t                  flags,
    output logic signed [OUT_WIDTH-1:0] res
);

    localparam int NW = RW + F + 2;
    localparam int QW = F + 1;

    logic [NW-1:0]      rem_reg  [QW];
    logic [NW-1:0]      den_reg  [QW];
    logic [QW-1:0]      q_reg    [QW];
    tun_flags_t         flg_reg  [QW];
    logic [NW-1:0]      num0, den0;
    logic signed [QW:0] qs;
    logic signed [OUT_WIDTH-1:0] res_reg, res_next;

    // Rounding: floor((mag * 2^(F+1) + len) / (2 * len)).
    assign num0 = (NW'(mag) << (F + 1)) + NW'(len);
    assign den0 = NW'(len) << 1;

    genvar k;
    for (k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = F - k;
        logic [NW-1:0] rem_in, den_in, dsh, rem_next;
        logic [QW-1:0] q_in, q_next;
        tun_flags_t    flg_in;

        if (k == 0)
        begin : g_first
            assign rem_in = num0;
            assign den_in = den0;
            assign q_in   = '0;
            assign flg_in = flags;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign flg_in = flg_reg[k-1];
        end

        assign dsh = den_in << B;

        always_comb
        begin
            if (rem_in >= dsh)
            begin
                rem_next = rem_in - dsh;
                q_next   = q_in | (QW'(1) << B);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_in;
            q_reg[k]   <= q_next;
            flg_reg[k] <= flg_in;
        end
    end

    // Apply the sign, and force zero for a degenerate triangle.
    assign qs = flg_reg[QW-1].neg ? -$signed({1'b0, q_reg[QW-1]})
                                  : $signed({1'b0, q_reg[QW-1]});
    assign res_next = flg_reg[QW-1].zero ? '0 : OUT_WIDTH'(qs);

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* rtl/core/triangle_unit_normal_core.sv */
// Throughput: one triangle per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the square root (one root bit per stage) and the three dividers.
// The receiver cannot stall: done pulses for one cycle with the result.
// Reset clears the valid pipeline and sets min_length to 6554; data registers are not reset.
module triangle_unit_normal_core
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [MINLEN_WIDTH-1:0]       cfg_data,
    output logic                          done,
    output logic signed [OUT_WIDTH-1:0]   normal_x,
    output logic signed [OUT_WIDTH-1:0]   normal_y,
    output logic signed [OUT_WIDTH-1:0]   normal_z,
    output logic                          valid_res
);

`include "assert_macros.svh"

    localparam int EW   = COORD_WIDTH + 1;
    localparam int MW   = 2 * COORD_WIDTH + 1;
    localparam int RW   = 2 * COORD_WIDTH + 2;
    localparam int SW   = 2 * RW;
    localparam int PW   = 3 * (MW + 1);
    localparam int CMPW = (RW > MINLEN_WIDTH) ? RW : MINLEN_WIDTH;
    localparam int LAT  = RW + NORMAL_FRAC_BITS + 8;

    logic [MINLEN_WIDTH-1:0] min_length_reg, min_length_next;
    logic [LAT-1:0]          vld_reg, vld_next;
    logic                    accept;

    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] f_reg [3];
    logic signed [EW-1:0] e_next [3];
    logic signed [EW-1:0] f_next [3];

    logic [MW-1:0]   mag  [3];
    logic            neg  [3];
    logic [2*MW-1:0] sq   [3];

    logic [SW-1:0]   sum_reg, sum_next;
    logic [PW-1:0]   side_reg, side_next, side_out;
    logic [RW-1:0]   root;

    logic [RW-1:0]   len_reg;
    logic [MW-1:0]   pmag_reg [3];
    tun_flags_t      pflg_reg [3];
    logic            degen;
    logic            deg_pipe_unused;

    logic [NORMAL_FRAC_BITS+1:0] deg_reg, deg_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Threshold register write.
    assign min_length_next = (cfg_valid && cfg_ready) ? cfg_data : min_length_reg;

    // Valid pipeline that follows each beat to the output.
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MINLEN_RESET;
            vld_reg        <= '0;
        end
        else
        begin
            min_length_reg <= min_length_next;
            vld_reg        <= vld_next;
        end
    end

    // Edge vectors from the first vertex.
    assign e_next[0] = EW'(b_x) - EW'(a_x);
    assign e_next[1] = EW'(b_y) - EW'(a_y);
    assign e_next[2] = EW'(b_z) - EW'(a_z);
    assign f_next[0] = EW'(c_x) - EW'(a_x);
    assign f_next[1] = EW'(c_y) - EW'(a_y);
    assign f_next[2] = EW'(c_z) - EW'(a_z);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i] <= e_next[i];
            f_reg[i] <= f_next[i];
        end
    end

    // Three cross product lanes.
    tun_cross_lane #(.EW(EW), .MW(MW)) u_lane_x (
        .clk (clk), .e_a (e_reg[1]), .f_b (f_reg[2]), .e_b (e_reg[2]), .f_a (f_reg[1]),
        .mag (mag[0]), .neg (neg[0]), .sq (sq[0])
    );
    tun_cross_lane #(.EW(EW), .MW(MW)) u_lane_y (
        .clk (clk), .e_a (e_reg[2]), .f_b (f_reg[0]), .e_b (e_reg[0]), .f_a (f_reg[2]),
        .mag (mag[1]), .neg (neg[1]), .sq (sq[1])
    );
    tun_cross_lane #(.EW(EW), .MW(MW)) u_lane_z (
        .clk (clk), .e_a (e_reg[0]), .f_b (f_reg[1]), .e_b (e_reg[1]), .f_a (f_reg[0]),
        .mag (mag[2]), .neg (neg[2]), .sq (sq[2])
    );

    // Merge: sum of squares, with the components carried alongside.
    assign sum_next  = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    assign side_next = {neg[2], mag[2], neg[1], mag[1], neg[0], mag[0]};

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        side_reg <= side_next;
    end

    tun_isqrt #(.RW(RW), .PW(PW)) u_isqrt (
        .clk      (clk),
        .rad      (sum_reg),
        .side_in  (side_reg),
        .root     (root),
        .side_out (side_out)
    );

    // Degenerate check against the threshold, then hand off to the dividers.
    assign degen = (root == '0) || (CMPW'(root) < CMPW'(min_length_reg));

    always_ff @(posedge clk)
    begin
        len_reg <= root;
        for (int i = 0; i < 3; i++)
        begin
            pmag_reg[i]      <= side_out[i*(MW+1) +: MW];
            pflg_reg[i].neg  <= side_out[i*(MW+1) + MW];
            pflg_reg[i].zero <= degen;
        end
    end

    tun_div_lane #(.RW(RW), .MW(MW), .F(NORMAL_FRAC_BITS)) u_div_x (
        .clk (clk), .mag (pmag_reg[0]), .len (len_reg), .flags (pflg_reg[0]), .res (normal_x)
    );
    tun_div_lane #(.RW(RW), .MW(MW), .F(NORMAL_FRAC_BITS)) u_div_y (
        .clk (clk), .mag (pmag_reg[1]), .len (len_reg), .flags (pflg_reg[1]), .res (normal_y)
    );
    tun_div_lane #(.RW(RW), .MW(MW), .F(NORMAL_FRAC_BITS)) u_div_z (
        .clk (clk), .mag (pmag_reg[2]), .len (len_reg), .flags (pflg_reg[2]), .res (normal_z)
    );

    // Valid flag of the result follows the degenerate flag through the divider.
    assign deg_next = {deg_reg[NORMAL_FRAC_BITS:0], pflg_reg[0].zero};

    always_ff @(posedge clk)
    begin
        deg_reg <= deg_next;
    end

    assign deg_pipe_unused = 1'b0;
    assign valid_res = !deg_reg[NORMAL_FRAC_BITS+1] && !deg_pipe_unused;
    assign done      = vld_reg[LAT-1];

    // A degenerate result carries a zero normal.
    `ASSERT_IMPLIES(a_degen_zero, clk, rst_n, done && !valid_res,
        normal_x == '0 && normal_y == '0 && normal_z == '0)
    // A valid unit normal is never all zero.
    `ASSERT_IMPLIES(a_valid_nonzero, clk, rst_n, done && valid_res,
        normal_x != '0 || normal_y != '0 || normal_z != '0)
    // An accepted beat enters the valid pipeline.
    `ASSERT_NEXT(a_accept_tracked, clk, rst_n, accept, vld_reg[0])

endmodule
